### rtl/assert_macros.svh
// assertion macros used by the serial line editor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SLE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define SLE_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `SLE_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

### rtl/sle_pkg.sv
// shared types and constants of the serial line editor
package sle_pkg;

  localparam int unsigned LineLenDef = 32;
  localparam int unsigned MaxResults = 32;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_RX   = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChSpace = 8'h20;

endpackage

### rtl/sle_in_if.sv
// handshake channel carrying command items into the editor
interface sle_in_if;
  import sle_pkg::*;

  logic       valid;
  logic       ready;
  cmd_e       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

### rtl/sle_out_if.sv
// handshake channel carrying result items out of the editor
interface sle_out_if;
  import sle_pkg::*;

  logic       valid;
  logic       ready;
  kind_e      kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

### rtl/serial_line_editor.sv
// serial line editor: echo, line store in memory and line read-out
//
//  channel | dir | payload                  | handshake
//  rx_i    | in  | cmd, rx_byte             | valid / ready
//  tx_o    | out | kind, out_byte, last     | valid / ready
//
//  receive item: at most one echo item, three for a backspace that removes a byte
//  read item: the line store is walked through its single read port, one entry a
//  cycle while tx_o does not stall, up to the first zero or to the lesser of
//  LineLen and MaxResults entries
//  reset clears per-entry valid flags at once, so no clearing pass is needed
//  a stalled tx_o holds the walk; rx_i is taken only between items
`include "assert_macros.svh"

module serial_line_editor #(
  parameter int unsigned LineLen = sle_pkg::LineLenDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  sle_in_if.sink     rx_i,
  sle_out_if.source  tx_o
);
  import sle_pkg::*;

  localparam int unsigned AW  = $clog2(LineLen);
  localparam int unsigned CW  = $clog2(LineLen + 1);
  localparam int unsigned Lim = (LineLen < MaxResults) ? LineLen : MaxResults;
  localparam logic [AW-1:0] LastIdx = AW'(Lim - 1);
  localparam logic [CW-1:0] CurMax  = CW'(LineLen);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS1,
    S_BS2,
    S_RD,
    S_FIN
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  function automatic logic is_line_char(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F;
  endfunction

  function automatic res_t mk_res(kind_e k, logic [7:0] d, logic l);
    res_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  state_e          state_q, state_d;
  logic [CW-1:0]   cursor_q, cursor_d;
  logic            line_ready_q, line_ready_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [7:0]      pend_q, pend_d;
  logic            pend_vld_q, pend_vld_d;
  logic            out_vld_q, out_vld_d;
  res_t            res_q, res_d;

  // line store and its valid flags
  logic [7:0]        mem_q [LineLen];
  logic [LineLen-1:0] valid_q;
  logic [7:0]        rd_data_q;
  logic              rd_vld_q;

  logic            wr_en, rd_en, clr_one, clr_all;
  logic [AW-1:0]   wr_addr, rd_addr, clr_addr;
  logic [7:0]      wr_data;
  logic            in_acc, out_free;
  logic [CW-1:0]   cur_dec;
  logic [7:0]      rd_byte;

  assign out_free = !out_vld_q || tx_o.ready;
  assign rx_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc = rx_i.valid && rx_i.ready;
  assign cur_dec = cursor_q - CW'(1);
  assign rd_byte = rd_vld_q ? rd_data_q : 8'h00;

  assign tx_o.valid    = out_vld_q;
  assign tx_o.kind     = res_q.kind;
  assign tx_o.out_byte = res_q.data;
  assign tx_o.last     = res_q.last;

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    line_ready_d = line_ready_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    out_vld_d    = out_vld_q && !tx_o.ready;
    res_d        = res_q;
    wr_en        = 1'b0;
    wr_addr      = cursor_q[AW-1:0];
    wr_data      = rx_i.rx_byte;
    rd_en        = 1'b0;
    rd_addr      = idx_q;
    clr_one      = 1'b0;
    clr_addr     = cur_dec[AW-1:0];
    clr_all      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (rx_i.cmd == CMD_RX) begin
            if (rx_i.rx_byte == ChCr) begin
              out_vld_d    = 1'b1;
              res_d        = mk_res(KIND_ECHO, ChCr, 1'b1);
              line_ready_d = 1'b1;
              cursor_d     = '0;
            end else if (rx_i.rx_byte == ChBs || rx_i.rx_byte == ChDel) begin
              if (cursor_q != '0) begin
                out_vld_d = 1'b1;
                res_d     = mk_res(KIND_ECHO, ChBs, 1'b0);
                cursor_d  = cur_dec;
                clr_one   = 1'b1;
                state_d   = S_BS1;
              end
            end else if (is_line_char(rx_i.rx_byte) && cursor_q < CurMax) begin
              wr_en     = 1'b1;
              out_vld_d = 1'b1;
              res_d     = mk_res(KIND_ECHO, rx_i.rx_byte, 1'b1);
              cursor_d  = cursor_q + CW'(1);
            end
          end else if (!line_ready_q) begin
            out_vld_d = 1'b1;
            res_d     = mk_res(KIND_NONE, 8'h00, 1'b1);
          end else begin
            // start the walk at slot zero
            rd_en      = 1'b1;
            rd_addr    = '0;
            idx_d      = '0;
            pend_vld_d = 1'b0;
            state_d    = S_RD;
          end
        end
      end
      S_BS1: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          res_d     = mk_res(KIND_ECHO, ChSpace, 1'b0);
          state_d   = S_BS2;
        end
      end
      S_BS2: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          res_d     = mk_res(KIND_ECHO, ChBs, 1'b1);
          state_d   = S_IDLE;
        end
      end
      S_RD: begin
        // one byte held back so that the final one can carry last
        if (rd_byte == 8'h00) begin
          state_d = S_FIN;
        end else if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d = 1'b1;
            res_d     = mk_res(KIND_LINE, pend_q, 1'b0);
          end
          pend_d     = rd_byte;
          pend_vld_d = 1'b1;
          if (idx_q == LastIdx) begin
            state_d = S_FIN;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q + AW'(1);
            idx_d   = idx_q + AW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          res_d        = pend_vld_q ? mk_res(KIND_LINE, pend_q, 1'b1)
                                    : mk_res(KIND_EMPTY, 8'h00, 1'b1);
          clr_all      = 1'b1;
          line_ready_d = 1'b0;
          pend_vld_d   = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cursor_q     <= '0;
      line_ready_q <= 1'b0;
      idx_q        <= '0;
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      pend_q       <= 8'h00;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      line_ready_q <= line_ready_d;
      idx_q        <= idx_d;
      pend_vld_q   <= pend_vld_d;
      out_vld_q    <= out_vld_d;
      pend_q       <= pend_d;
      res_q        <= res_d;
    end
  end

  // an entry whose flag is clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_all) begin
      valid_q <= '0;
    end else begin
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      if (clr_one) valid_q[clr_addr] <= 1'b0;
    end
  end

  // writes happen only between items and reads only during a walk, so no overlap
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= valid_q[rd_addr];
    end
  end

  `SLE_ASSERT(a_cursor_range, clk_i, rst_ni, cursor_q <= CurMax, "cursor beyond line length")
  `SLE_ASSERT(a_walk_needs_line, clk_i, rst_ni,
              (state_q == S_RD) |-> line_ready_q, "walk without a ready line")
  `SLE_ASSERT(a_fin_clears, clk_i, rst_ni,
              (state_q == S_FIN && out_free) |=> (!line_ready_q && valid_q == '0),
              "read-out left the store set")
  `SLE_ASSERT_NEVER(a_mid_item_idle, clk_i, rst_ni,
                    out_vld_q && !res_q.last && state_q == S_IDLE,
                    "non-final item pending while idle")

endmodule

### sim/tb_serial_line_editor.sv
// self-checking testbench of the serial line editor: echo, editing and line read-out
`timescale 1ns / 100ps

module tb_serial_line_editor;
  import sle_pkg::*;

  localparam int unsigned LineLen   = LineLenDef;
  localparam int unsigned RandItems = 360;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } tx_item_t;

  // mirror of the editor state; predicts the output items of each command item
  class line_scoreboard;
    logic [7:0] line_mem [LineLen];
    int         cursor;
    logic       line_rdy;
    tx_item_t   due_q [$];
    int         errors, n_cmds, n_idle, n_echo, n_line_bytes, n_reads, n_empty, n_none,
                n_dropped, n_full_reads;

    function new();
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      cursor   = 0;
      line_rdy = 1'b0;
    endfunction

    function void push_due(kind_e k, logic [7:0] d);
      tx_item_t t;
      t.kind = k;
      t.data = d;
      t.last = 1'b0;
      due_q.push_back(t);
    endfunction

    function bit is_line_char(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
             b == "-" || b == "_";
    endfunction

    function void take_command(cmd_e c, logic [7:0] b);
      int  n;
      int  i;
      bit  stop;
      n = 0;
      n_cmds++;
      if (c == CMD_RX) begin
        if (b == ChCr) begin
          push_due(KIND_ECHO, ChCr);
          n = 1;
          line_rdy = 1'b1;
          cursor = 0;
        end else if (b == ChBs || b == ChDel) begin
          if (cursor != 0) begin
            push_due(KIND_ECHO, ChBs);
            push_due(KIND_ECHO, ChSpace);
            push_due(KIND_ECHO, ChBs);
            n = 3;
            cursor--;
            line_mem[cursor] = 8'h00;
          end
        end else if (is_line_char(b)) begin
          if (cursor < LineLen) begin
            line_mem[cursor] = b;
            cursor++;
            push_due(KIND_ECHO, b);
            n = 1;
          end else begin
            n_dropped++;
          end
        end
        n_echo += n;
      end else if (!line_rdy) begin
        push_due(KIND_NONE, 8'h00);
        n = 1;
        n_none++;
      end else begin
        stop = 1'b0;
        for (i = 0; i < LineLen && !stop; i++) begin
          if (line_mem[i] == 8'h00 || n >= MaxResults) begin
            stop = 1'b1;
          end else begin
            push_due(KIND_LINE, line_mem[i]);
            n++;
          end
        end
        if (n == 0) begin
          push_due(KIND_EMPTY, 8'h00);
          n = 1;
          n_empty++;
        end else begin
          n_reads++;
          n_line_bytes += n;
          if (n == LineLen) n_full_reads++;
        end
        foreach (line_mem[j]) line_mem[j] = 8'h00;
        line_rdy = 1'b0;
      end
      if (n > 0) due_q[due_q.size() - 1].last = 1'b1;
      else n_idle++;
    endfunction

    function void check_result(kind_e k, logic [7:0] d, logic l);
      tx_item_t e;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: kind %0d byte 0x%h last %b", $time, k, d, l);
        return;
      end
      e = due_q.pop_front();
      if (e.kind !== k || e.data !== d || e.last !== l) begin
        errors++;
        $display("%0t: mismatch: expected kind %0d byte 0x%h last %b,", $time,
                 e.kind, e.data, e.last);
        $display("  got kind %0d byte 0x%h last %b", k, d, l);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sle_in_if  rx_if ();
  sle_out_if tx_if ();

  line_scoreboard sb = new();

  int burst_left;
  int n_pauses;

  serial_line_editor #(
    .LineLen (LineLen)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tx_o   (tx_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.cmd     = CMD_RX;
    rx_if.rx_byte = 8'h00;
    tx_if.ready   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // both handshakes are sampled at the rising edge; inputs noted before outputs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) sb.take_command(rx_if.cmd, rx_if.rx_byte);
      if (tx_if.valid && tx_if.ready) sb.check_result(tx_if.kind, tx_if.out_byte, tx_if.last);
    end
  end

  // receiver back-pressure: a stall pattern chosen at random from four modes
  initial begin
    int         mode;
    int         cyc;
    logic [7:0] mask;
    mode = 0;
    cyc  = 0;
    mask = 8'hff;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (cyc % 64 == 0) begin
        mode = $urandom_range(0, 3);
        mask = 8'($urandom_range(0, 255));
        mask[0] = 1'b1;
      end
      case (mode)
        0: tx_if.ready <= 1'b1;
        1: tx_if.ready <= ($urandom_range(0, 1) == 1);
        2: tx_if.ready <= mask[cyc % 8];
        default: tx_if.ready <= ($urandom_range(0, 4) != 0);
      endcase
      cyc++;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] line_char(int idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? 8'("-") : 8'("_");
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  // with valid still high, so the caller must drive valid in that same step
  task automatic send_cmd(cmd_e c, logic [7:0] b);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 5);
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 8);
    end
    rx_if.valid   <= 1'b1;
    rx_if.cmd     <= c;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic pause_until_drained();
    rx_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    n_pauses++;
  endtask

  task automatic send_line(int len);
    int j;
    int sel;
    for (j = 0; j < len; j++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) send_cmd(CMD_RX, ($urandom_range(0, 1) == 1) ? ChBs : ChDel);
      else if (sel == 1) send_cmd(CMD_RX, rand_byte());
      else send_cmd(CMD_RX, line_char($urandom_range(0, 63)));
    end
    send_cmd(CMD_RX, ChCr);
  endtask

  initial begin
    int  len;
    int  pick;
    bit  first_long;
    burst_left = 0;
    n_pauses   = 0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // directed part
    send_cmd(CMD_READ, 8'h00);       // read with no line ready
    send_cmd(CMD_RX, ChBs);          // backspace at start of line
    send_cmd(CMD_RX, ChDel);
    send_cmd(CMD_RX, ChCr);
    send_cmd(CMD_READ, 8'hff);       // empty line
    send_cmd(CMD_RX, "A");
    send_cmd(CMD_RX, "z");
    send_cmd(CMD_RX, "0");
    send_cmd(CMD_RX, "9");
    send_cmd(CMD_RX, "-");
    send_cmd(CMD_RX, "_");
    send_cmd(CMD_RX, 8'h00);         // bytes that are ignored
    send_cmd(CMD_RX, 8'hff);
    send_cmd(CMD_RX, 8'h80);
    send_cmd(CMD_RX, ChSpace);
    send_cmd(CMD_RX, 8'h0a);
    send_cmd(CMD_RX, ChBs);
    send_cmd(CMD_RX, ChDel);
    send_cmd(CMD_RX, ChCr);
    send_cmd(CMD_RX, "x");           // new line overwrites the old one from slot zero
    send_cmd(CMD_RX, ChCr);
    send_cmd(CMD_READ, 8'h5a);
    send_cmd(CMD_READ, 8'ha5);       // flag already cleared
    send_cmd(CMD_RX, "q");           // cursor kept by the read, so q goes to slot zero of the cleared store
    send_cmd(CMD_RX, ChCr);
    send_cmd(CMD_READ, 8'h00);
    pause_until_drained();

    // random part: mostly well-formed lines, some noise
    first_long = 1'b1;
    while (sb.n_cmds < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (first_long) len = 36;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(28, 38);
        else len = $urandom_range(0, 12);
        first_long = 1'b0;
        send_line(len);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_cmd(CMD_READ, rand_byte());
        end else if (pick == 7) begin
          send_cmd(CMD_READ, rand_byte());
          send_cmd(CMD_READ, rand_byte());
        end
      end else if (pick < 96) begin
        send_cmd(cmd_e'($urandom_range(0, 1)), rand_byte());
      end else begin
        pause_until_drained();
      end
    end
    rx_if.valid <= 1'b0;

    while (sb.pending() != 0) @(negedge clk_i);
    repeat (LineLen + 8) @(negedge clk_i);

    $display("covered %0d commands (%0d ignored, %0d chars dropped at full store), %0d pauses",
             sb.n_cmds, sb.n_idle, sb.n_dropped, n_pauses);
    $display("%0d echo items, %0d lines read (%0d full) with %0d bytes, %0d empty, %0d no line",
             sb.n_echo, sb.n_reads, sb.n_full_reads, sb.n_line_bytes, sb.n_empty, sb.n_none);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d items outstanding", sb.pending());
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_in_if.sv
rtl/sle_out_if.sv
rtl/serial_line_editor.sv
sim/tb_serial_line_editor.sv
